// ----- src/bffsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bffsc_pkg
// Shared constants and command codes for the bitmap find-first set/clear core.
// ----------------------------------------------------------------------------
package bffsc_pkg;

  // Default geometry of the bit store
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned MaxWordsDef = 1024;

  // Fixed field widths
  localparam int unsigned IdxW   = 15;
  localparam int unsigned CountW = 11;
  localparam int unsigned CmdW   = 2;

  // Word count after reset
  localparam int unsigned WordCountRst = 1024;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_FIND_SET   = 2'd2,
    CMD_FIND_CLEAR = 2'd3
  } cmd_e;

endpackage

// ----- src/bitmap_find_first_set_clear_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_find_first_set_clear_core
// Bit array in a word-wide RAM: single-bit write and read, and searches for
// the lowest set or lowest clear bit at or above a start position.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one request transaction:
//   cmd_i, bit_index_i, write_value_i. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result transaction per request.
//   The word count register is written over cfg_valid_i / cfg_ready_o; the
//   user must do so only while the core is idle, which the core does not
//   enforce. Values above MAX_WORDS act as MAX_WORDS.
// Sequencing
//   Reads, writes and out-of-range requests: the single RAM read port takes
//   the address in the accept cycle and gives the data in the next; the
//   write-back and the result follow once the output register is free.
//   A search that misses in its start word scans one further word per cycle.
// Reset
//   After rst_ni releases, a clearing pass writes zero to every RAM word.
//   in_stall_o stays high meanwhile; configuration writes are still taken.
// Back-pressure
//   Results sit in an output register. A new request is taken while a result
//   waits; a finished result that cannot be handed over holds the core.
// ----------------------------------------------------------------------------
module bitmap_find_first_set_clear_core #(
  parameter int unsigned WORD_BITS = bffsc_pkg::WordBitsDef,
  parameter int unsigned MAX_WORDS = bffsc_pkg::MaxWordsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bffsc_pkg::CountW-1:0] cfg_word_count_i,
  // request
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bffsc_pkg::CmdW-1:0]  cmd_i,
  input  logic [bffsc_pkg::IdxW-1:0]  bit_index_i,
  input  logic                        write_value_i,
  // result
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        bit_read_o,
  output logic                        found_o,
  output logic [bffsc_pkg::IdxW-1:0]  found_position_o,
  output logic                        index_error_o
);

  import bffsc_pkg::*;

  localparam int unsigned AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned ShW  = $clog2(WORD_BITS);
  // word index = (index * Recip) >> RecipK, exact for all 15-bit indices
  localparam int unsigned RecipK = IdxW + ShW + 1;
  localparam longint unsigned RecipVal =
      ((64'd1 << RecipK) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ProdW = IdxW + RecipK;
  localparam logic [ProdW-1:0] Recip = ProdW'(RecipVal);
  localparam logic [IdxW-1:0] WordBitsIdx = IdxW'(WORD_BITS);
  localparam logic [CountW-1:0] MaxWordsCnt =
      (MAX_WORDS > 2047) ? {CountW{1'b1}} : CountW'(MAX_WORDS);
  localparam logic [CountW-1:0] NwRst =
      (WordCountRst > MAX_WORDS) ? CountW'(MAX_WORDS) : CountW'(WordCountRst);
  localparam logic [AW-1:0] ClrLast = AW'(MAX_WORDS - 1);

  // state codes
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  // lowest set bit; caller guarantees w is not zero
  function automatic logic [ShW-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [ShW-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = ShW'(i);
    end
    return n;
  endfunction

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [CountW-1:0] nw_q, nw_d;

  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              val_q, val_d;
  logic [IdxW-1:0]   wi_q, wi_d;
  logic              err_q, err_d;
  logic [CountW-1:0] scan_q, scan_d;
  logic [IdxW-1:0]   base_q, base_d;

  logic              out_valid_q, out_valid_d;
  logic              bit_read_q, bit_read_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic              ierr_q, ierr_d;
  logic              out_load;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // request decode (accept cycle)
  logic [ProdW-1:0]  idx_prod;
  logic [IdxW-1:0]   wi_in;
  logic              err_in;

  // data-cycle helpers
  logic [IdxW-1:0]      base_first;
  logic [ShW-1:0]       sh;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] cand_first;
  logic [WORD_BITS-1:0] keep;
  logic [WORD_BITS-1:0] word_mod;
  logic [CountW-1:0]    wi_next;
  logic [CountW-1:0]    scan_next;
  logic                 can_load;

  bffsc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign idx_prod = ProdW'(bit_index_i) * Recip;
  assign wi_in    = IdxW'(idx_prod >> RecipK);
  assign err_in   = (wi_in >= IdxW'(nw_q));

  assign base_first = wi_q * WordBitsIdx;
  assign sh         = ShW'(idx_q - base_first);

  // candidate bits: inverted for a clear search
  assign cand = (cmd_q == CMD_FIND_CLEAR) ? ~ram_rdata : ram_rdata;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      keep[i]     = (i >= int'(sh));
      word_mod[i] = (i == int'(sh)) ? val_q : ram_rdata[i];
    end
  end

  assign cand_first = cand & keep;
  assign wi_next    = CountW'(wi_q) + 1'b1;
  assign scan_next  = scan_q + 1'b1;
  assign can_load   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    nw_d        = nw_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    val_d       = val_q;
    wi_d        = wi_q;
    err_d       = err_q;
    scan_d      = scan_q;
    base_d      = base_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(wi_q);
    ram_wdata   = word_mod;
    ram_re      = 1'b0;
    ram_raddr   = AW'(wi_in);
    out_load    = 1'b0;
    bit_read_d  = 1'b0;
    found_d     = 1'b0;
    pos_d       = '0;
    ierr_d      = 1'b0;

    if (cfg_valid_i) begin
      nw_d = (cfg_word_count_i > MaxWordsCnt) ? CountW'(MAX_WORDS) : cfg_word_count_i;
    end

    case (state_q)
      ST_CLR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_re  = !err_in;
          cmd_d   = cmd_i;
          idx_d   = bit_index_i;
          val_d   = write_value_i;
          wi_d    = wi_in;
          err_d   = err_in;
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (err_q) begin
          ierr_d   = 1'b1;
          out_load = can_load;
        end else begin
          case (cmd_q)
            CMD_WRITE: begin
              ram_we   = can_load;
              out_load = can_load;
            end
            CMD_READ: begin
              bit_read_d = ram_rdata[sh];
              out_load   = can_load;
            end
            default: begin
              if (cand_first != '0) begin
                found_d  = 1'b1;
                pos_d    = base_first + IdxW'(lowest_set(cand_first));
                out_load = can_load;
              end else if (wi_next < nw_q) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(wi_next);
                scan_d    = wi_next;
                base_d    = base_first + WordBitsIdx;
                state_d   = ST_SCAN;
              end else begin
                out_load = can_load;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // one word checked per cycle, next read issued alongside
        if (cand != '0) begin
          found_d  = 1'b1;
          pos_d    = base_q + IdxW'(lowest_set(cand));
          out_load = can_load;
        end else if (scan_next < nw_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(scan_next);
          scan_d    = scan_next;
          base_d    = base_q + WordBitsIdx;
        end else begin
          out_load = can_load;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      nw_q        <= NwRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      nw_q        <= nw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    wi_q   <= wi_d;
    err_q  <= err_d;
    scan_q <= scan_d;
    base_q <= base_d;
    if (out_load) begin
      bit_read_q <= bit_read_d;
      found_q    <= found_d;
      pos_q      <= pos_d;
      ierr_q     <= ierr_d;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign bit_read_o       = bit_read_q;
  assign found_o          = found_q;
  assign found_position_o = pos_q;
  assign index_error_o    = ierr_q;

endmodule

// ----- src/bffsc_ram.sv -----
// ----------------------------------------------------------------------------
// bffsc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap find-first set/clear core. A shadow copy
// of the bit store and the word count predicts every result at request
// acceptance, and each result transaction is compared field by field in
// order. Directed requests cover reset state, range edges and the word count
// extremes. Random runs of writes, each followed by a search, then run under
// three idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bffsc_pkg::*;

  localparam int unsigned WordBits    = WordBitsDef;
  localparam int unsigned MaxWords    = MaxWordsDef;
  localparam int unsigned QuietLimit  = 10000;  // clearing pass + full scan, several times over
  localparam int unsigned DrainCycles = MaxWords + 64;
  localparam int unsigned PrintLimit  = 100;

  typedef struct packed {
    logic            bit_read;
    logic            found;
    logic [IdxW-1:0] found_position;
    logic            index_error;
  } bitmap_result_t;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_word_count_i = '0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [CmdW-1:0]   cmd_i            = CMD_READ;
  logic [IdxW-1:0]   bit_index_i      = '0;
  logic              write_value_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic              bit_read_o;
  logic              found_o;
  logic [IdxW-1:0]   found_position_o;
  logic              index_error_o;

  // shadow of the store and the word count register
  logic [WordBits-1:0] shadow_words [MaxWords];
  logic [CountW-1:0]   shadow_word_count;
  bitmap_result_t      awaited_results [$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned quiet_cycles   = 0;

  always #6 clk_i = ~clk_i;

  bitmap_find_first_set_clear_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_word_count_i (cfg_word_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .bit_index_i      (bit_index_i),
    .write_value_i    (write_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .bit_read_o       (bit_read_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .index_error_o    (index_error_o)
  );

  // oversized counts clamp to the store depth
  function automatic int unsigned active_words();
    return (shadow_word_count > MaxWords) ? MaxWords : int'(shadow_word_count);
  endfunction

  // Applies one request to the shadow store and returns its result.
  function automatic bitmap_result_t predict_bitmap_result(input cmd_e op,
                                                           input logic [IdxW-1:0] idx,
                                                           input logic value);
    bitmap_result_t      res;
    int unsigned         words;
    int unsigned         wi;
    int unsigned         bi;
    int unsigned         w;
    int unsigned         b;
    logic [WordBits-1:0] scan;
    res   = '0;
    words = active_words();
    if (idx >= words * WordBits) begin
      res.index_error = 1'b1;
      return res;
    end
    wi = idx / WordBits;
    bi = idx % WordBits;
    case (op)
      CMD_WRITE: begin
        shadow_words[wi][bi] = value;
      end
      CMD_READ: begin
        res.bit_read = shadow_words[wi][bi];
      end
      default: begin
        // start word is masked below the start bit, later words are whole
        for (w = wi; w < words && !res.found; w++) begin
          scan = (op == CMD_FIND_SET) ? shadow_words[w] : ~shadow_words[w];
          if (w == wi) scan &= {WordBits{1'b1}} << bi;
          for (b = 0; b < WordBits && !res.found; b++) begin
            if (scan[b]) begin
              res.found          = 1'b1;
              res.found_position = IdxW'(w * WordBits + b);
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    // keep the log bounded when everything goes wrong
    if (mismatch_count < PrintLimit)
      $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Sends one request transaction; valid stays high afterwards so that
  // back-to-back requests never lower and raise it in one step.
  task automatic send_request(input cmd_e op, input logic [IdxW-1:0] idx,
                              input logic value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= op;
    bit_index_i   <= idx;
    write_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    awaited_results.push_back(predict_bitmap_result(op, idx, value));
  endtask

  // Drops valid and waits until every awaited result has come back.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_word_count(input logic [CountW-1:0] value);
    drain_requests();
    cfg_valid_i      <= 1'b1;
    cfg_word_count_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_word_count = value;
    cfg_valid_i      <= 1'b0;
  endtask

  // Reset word count, store fresh from the clearing pass; the set searches from
  // bit 0 run across all 1024 words.
  task automatic test_after_reset();
    send_request(CMD_READ,       15'd0,     1'b0);
    send_request(CMD_FIND_SET,   15'd0,     1'b0);  // empty store, no match
    send_request(CMD_FIND_CLEAR, 15'd32767, 1'b1);
    send_request(CMD_WRITE,      15'd32767, 1'b1);
    send_request(CMD_FIND_SET,   15'd0,     1'b0);  // match in the very last bit
    send_request(CMD_FIND_CLEAR, 15'd32767, 1'b0);  // no match
    send_request(CMD_READ,       15'd32767, 1'b0);
  endtask

  task automatic test_range_edges();
    write_word_count(11'd3);
    send_request(CMD_WRITE,      15'd40, 1'b1);
    send_request(CMD_WRITE,      15'd2,  1'b1);
    send_request(CMD_FIND_SET,   15'd3,  1'b0);  // bit 2 below start, must skip to 40
    send_request(CMD_FIND_CLEAR, 15'd2,  1'b0);  // clear search masks bits below start
    send_request(CMD_WRITE,      15'd95, 1'b1);  // last bit in range
    send_request(CMD_FIND_SET,   15'd41, 1'b0);
    send_request(CMD_WRITE,      15'd96, 1'b1);  // first bit out of range
    send_request(CMD_READ,       15'd96, 1'b0);
    send_request(CMD_FIND_SET,   15'd96, 1'b0);
    send_request(CMD_FIND_CLEAR, 15'd32767, 1'b0);
  endtask

  task automatic test_word_count_extremes();
    // zero words: everything is out of range
    write_word_count(11'd0);
    send_request(CMD_WRITE,      15'd0, 1'b1);
    send_request(CMD_READ,       15'd0, 1'b0);
    send_request(CMD_FIND_SET,   15'd0, 1'b0);
    send_request(CMD_FIND_CLEAR, 15'd0, 1'b0);
    // oversized count acts as the full depth; stored bits survive the change
    write_word_count(11'd2047);
    send_request(CMD_READ,       15'd32767, 1'b0);
    send_request(CMD_FIND_CLEAR, 15'd32736, 1'b0);
  endtask

  // One phase at a given word count: mostly runs of writes followed by a
  // search started inside the run, the rest single random requests.
  task automatic run_random_phase(input logic [CountW-1:0] count,
                                  input int unsigned n_items);
    int unsigned sent;
    int unsigned words;
    int unsigned run_start;
    int unsigned run_len;
    int unsigned k;
    logic        value;
    cmd_e        op;
    write_word_count(count);
    words = active_words();
    sent  = 0;
    while (sent < n_items) begin
      value = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 60) begin
        run_start = $urandom_range(0, words * WordBits - 1);
        run_len   = $urandom_range(1, 40);
        // keep the phase close to its item budget
        if (run_len > n_items - sent) run_len = n_items - sent;
        for (k = 0; k < run_len && run_start + k <= 32767; k++)
          send_request(CMD_WRITE, IdxW'(run_start + k), value);
        // usually hunt for the opposite value, so the search crosses the run
        if ($urandom_range(0, 3) != 0)
          op = value ? CMD_FIND_CLEAR : CMD_FIND_SET;
        else
          op = value ? CMD_FIND_SET : CMD_FIND_CLEAR;
        send_request(op, IdxW'(run_start + $urandom_range(0, run_len - 1)), value);
        sent += k + 1;
      end else begin
        op = cmd_e'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7)
          send_request(op, IdxW'($urandom_range(0, words * WordBits + WordBits - 1)), value);
        else
          send_request(op, IdxW'($urandom_range(0, 32767)), value);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned hold_pct);
    logic [CountW-1:0] counts [6] = '{11'd1, 11'd2, 11'd5, 11'd33, 11'd2047, 11'd1024};
    int unsigned       lengths [6] = '{35, 35, 35, 30, 20, 20};
    int unsigned       p;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (p = 0; p < 6; p++) run_random_phase(counts[p], lengths[p]);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  // result checker: oldest awaited result against each result transaction
  always @(posedge clk_i) begin
    bitmap_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (bit_read_o !== want.bit_read)
          report_mismatch("bit_read", bit_read_o, want.bit_read);
        if (found_o !== want.found)
          report_mismatch("found", found_o, want.found);
        if (found_position_o !== want.found_position)
          report_mismatch("found_position", found_position_o, want.found_position);
        if (index_error_o !== want.index_error)
          report_mismatch("index_error", index_error_o, want.index_error);
      end
    end
  end

  // watchdog: counts cycles without any transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("watchdog: %0d cycles without a transaction", QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_word_count = CountW'(WordCountRst);
    send_idle_pct     = 19;
    stall_pct         = 69;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_range_edges();
    test_word_count_extremes();
    test_random_traffic(19, 69);
    test_random_traffic(69, 19);
    test_random_traffic(0, 0);

    drain_requests();
    // a stray late result would need up to a full scan to show
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bffsc_pkg.sv
src/bffsc_ram.sv
src/bitmap_find_first_set_clear_core.sv
tb/sv/testbench.sv
